@@ rtl/core/ivt_pkg.sv @@
// shared types, constants and helpers of the instance vertex transform
`timescale 1ns / 1ps
`default_nettype none

package ivt_pkg;

  // fraction bits of sine and cosine
  localparam int TRIG_BITS = 16;
  // signed width of a sine or cosine value
  localparam int TW = TRIG_BITS + 2;
  // signed width of a coordinate between the rotations
  localparam int CW = 35;
  // cordic iterations and datapath widths
  localparam int CORDIC_ITERS = 30;
  localparam int CXW = 34;
  localparam int CZW = 33;
  localparam logic signed [CXW-1:0] CORDIC_GAIN = CXW'(652032874);

  // register indexes of the configuration port
  localparam logic [2:0] REG_SCALE    = 3'd0;
  localparam logic [2:0] REG_ANGLE_X  = 3'd1;
  localparam logic [2:0] REG_ANGLE_Y  = 3'd2;
  localparam logic [2:0] REG_ANGLE_Z  = 3'd3;
  localparam logic [2:0] REG_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;
  localparam logic [2:0] REG_OFFSET_Z = 3'd6;

  typedef struct packed {
    logic signed [TW-1:0] cos_v;
    logic signed [TW-1:0] sin_v;
  } trig_t;

  // data that rides along a rotation untouched
  typedef struct packed {
    logic signed [CW-1:0] w;
    logic signed [31:0]   u;
    logic signed [31:0]   v;
    logic                 last;
  } side_t;

  // arctangent table, 2^32 per full turn
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;
      5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;
      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;
      5'd21: r = 32'd325;
      5'd22: r = 32'd162;
      5'd23: r = 32'd81;
      5'd24: r = 32'd40;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd2;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // clamp a wide signed value into signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] val);
    logic signed [31:0] r;
    if (!val[47] && (|val[46:31])) begin
      r = 32'sh7FFFFFFF;
    end else if (val[47] && !(&val[46:31])) begin
      r = 32'sh80000000;
    end else begin
      r = val[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ivt_trig.sv @@
// iterative cordic that derives cosine and sine of the three angles
`timescale 1ns / 1ps
`default_nettype none

module ivt_trig import ivt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] angle_x,
  input  wire logic [15:0] angle_y,
  input  wire logic [15:0] angle_z,
  input  wire logic        angle_write,
  output logic             trig_ok,
  output trig_t            trig_x,
  output trig_t            trig_y,
  output trig_t            trig_z
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [4:0] LAST_ITER = 5'(CORDIC_ITERS - 1);
  localparam logic signed [CXW-1:0] HALF_C = CXW'(1) <<< (29 - TRIG_BITS);

  state_t state;
  logic dirty;
  logic [1:0] axis;
  logic [4:0] iter;
  logic flip;
  logic signed [CXW-1:0] x;
  logic signed [CXW-1:0] y;
  logic signed [CZW-1:0] z;

  logic [1:0] ld_axis;
  logic [15:0] ld_ang;
  logic [31:0] ld_a;
  logic ld_flip;
  logic signed [CZW-1:0] ld_z;
  logic signed [CXW-1:0] x_next;
  logic signed [CXW-1:0] y_next;
  logic signed [CZW-1:0] z_next;
  logic signed [CZW-1:0] at;
  logic signed [CXW-1:0] cr;
  logic signed [CXW-1:0] sr;
  trig_t res;

  // starting vector for the next axis, left half plane turned by half a turn
  always_comb begin
    ld_axis = (state == ST_IDLE) ? 2'd0 : axis + 2'd1;
    case (ld_axis)
      2'd0:    ld_ang = angle_x;
      2'd1:    ld_ang = angle_y;
      default: ld_ang = angle_z;
    endcase
    ld_a = {ld_ang, 16'b0};
    ld_flip = ld_a[31] ^ ld_a[30];
    ld_a[31] = ld_a[31] ^ ld_flip;
    ld_z = CZW'($signed(ld_a));
  end

  // one micro-rotation
  always_comb begin
    at = $signed({1'b0, atan_entry(iter)});
    if (!z[CZW-1]) begin
      x_next = x - (y >>> iter);
      y_next = y + (x >>> iter);
      z_next = z - at;
    end else begin
      x_next = x + (y >>> iter);
      y_next = y - (x >>> iter);
      z_next = z + at;
    end
    cr = (x_next + HALF_C) >>> (30 - TRIG_BITS);
    sr = (y_next + HALF_C) >>> (30 - TRIG_BITS);
    res.cos_v = flip ? -cr[TW-1:0] : cr[TW-1:0];
    res.sin_v = flip ? -sr[TW-1:0] : sr[TW-1:0];
  end

  // sequencer over the three axes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dirty <= 1'b1;
      axis  <= 2'd0;
      iter  <= 5'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (dirty) begin
            state <= ST_RUN;
            axis  <= 2'd0;
            iter  <= 5'd0;
            x     <= CORDIC_GAIN;
            y     <= '0;
            z     <= ld_z;
            flip  <= ld_flip;
          end
        end
        ST_RUN: begin
          if (iter == LAST_ITER) begin
            case (axis)
              2'd0:    trig_x <= res;
              2'd1:    trig_y <= res;
              default: trig_z <= res;
            endcase
            iter <= 5'd0;
            if (axis == 2'd2) begin
              state <= ST_IDLE;
            end else begin
              axis <= axis + 2'd1;
              x    <= CORDIC_GAIN;
              y    <= '0;
              z    <= ld_z;
              flip <= ld_flip;
            end
          end else begin
            x <= x_next;
            y <= y_next;
            z <= z_next;
            iter <= iter + 5'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // a new angle asks for another pass
      if (angle_write) begin
        dirty <= 1'b1;
      end else if (state == ST_IDLE && dirty) begin
        dirty <= 1'b0;
      end
    end
  end

  assign trig_ok = (state == ST_IDLE) && !dirty;

endmodule

`default_nettype wire

@@ rtl/core/ivt_scale.sv @@
// two-stage uniform scale of the position and v flip
`timescale 1ns / 1ps
`default_nettype none

module ivt_scale import ivt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] tex_u,
  input  wire logic signed [31:0] tex_v,
  input  wire logic               last_in,
  input  wire logic [23:0]        scale_factor,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output logic signed [CW-1:0]    sx,
  output logic signed [CW-1:0]    sy,
  output logic signed [CW-1:0]    sz,
  output logic signed [31:0]      su,
  output logic signed [31:0]      sv,
  output logic                    slast
);

  localparam logic signed [56:0] HALF_S = 57'sd32768;

  logic v1;
  logic v2;
  logic rdy1;
  logic rdy2;
  logic signed [56:0] px;
  logic signed [56:0] py;
  logic signed [56:0] pz;
  logic signed [32:0] fv;
  logic signed [31:0] u1;
  logic last1;
  logic signed [24:0] sc;
  logic signed [56:0] rx;
  logic signed [56:0] ry;
  logic signed [56:0] rz;

  assign rdy2 = !v2 || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2;
  assign sc = $signed({1'b0, scale_factor});

  // round half up by 16
  assign rx = (px + HALF_S) >>> 16;
  assign ry = (py + HALF_S) >>> 16;
  assign rz = (pz + HALF_S) >>> 16;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // exact products
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      px <= pos_x * sc;
      py <= pos_y * sc;
      pz <= pos_z * sc;
      fv <= 33'sd65536 - 33'(tex_v);
      u1 <= tex_u;
      last1 <= last_in;
    end
  end

  // rounding and saturation
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sx <= CW'(sat32(rx[47:0]));
      sy <= CW'(sat32(ry[47:0]));
      sz <= CW'(sat32(rz[47:0]));
      sv <= sat32(48'(fv));
      su <= u1;
      slast <= last1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ivt_rotate.sv @@
// two-stage plane rotation: r0 = a*c - b*s, r1 = a*s + b*c
`timescale 1ns / 1ps
`default_nettype none

module ivt_rotate import ivt_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire logic signed [CW-1:0] a,
  input  wire logic signed [CW-1:0] b,
  input  wire side_t           side_in,
  input  wire trig_t           cs,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output logic signed [CW-1:0] r0,
  output logic signed [CW-1:0] r1,
  output side_t                side_out
);

  localparam int PW = CW + TW;
  localparam logic signed [PW:0] HALF_T = (PW + 1)'(1) <<< (TRIG_BITS - 1);

  logic v1;
  logic v2;
  logic rdy1;
  logic rdy2;
  logic signed [PW-1:0] p_ac;
  logic signed [PW-1:0] p_bs;
  logic signed [PW-1:0] p_as;
  logic signed [PW-1:0] p_bc;
  side_t side1;
  logic signed [PW:0] sum0;
  logic signed [PW:0] sum1;
  logic signed [PW:0] q0;
  logic signed [PW:0] q1;

  assign rdy2 = !v2 || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2;

  assign sum0 = (PW + 1)'(p_ac) - (PW + 1)'(p_bs);
  assign sum1 = (PW + 1)'(p_as) + (PW + 1)'(p_bc);
  assign q0 = (sum0 + HALF_T) >>> TRIG_BITS;
  assign q1 = (sum1 + HALF_T) >>> TRIG_BITS;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      p_ac <= a * cs.cos_v;
      p_bs <= b * cs.sin_v;
      p_as <= a * cs.sin_v;
      p_bc <= b * cs.cos_v;
      side1 <= side_in;
    end
  end

  // sums rounded half up
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      r0 <= q0[CW-1:0];
      r1 <= q1[CW-1:0];
      side_out <= side1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ivt_output.sv @@
// translation, saturation and the output register
`timescale 1ns / 1ps
`default_nettype none

module ivt_output import ivt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic signed [CW-1:0] x,
  input  wire logic signed [CW-1:0] y,
  input  wire logic signed [CW-1:0] z,
  input  wire logic signed [31:0] u,
  input  wire logic signed [31:0] v,
  input  wire logic               last,
  input  wire logic signed [31:0] offset_x,
  input  wire logic signed [31:0] offset_y,
  input  wire logic signed [31:0] offset_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_u,
  output logic signed [31:0]      out_v,
  output logic                    last_out
);

  logic rdy;
  logic signed [47:0] tx;
  logic signed [47:0] ty;
  logic signed [47:0] tz;

  assign rdy = !out_valid || out_ready;
  assign up_ready = rdy;
  assign tx = 48'(x) + 48'(offset_x);
  assign ty = 48'(y) + 48'(offset_y);
  assign tz = 48'(z) + 48'(offset_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy) begin
      out_valid <= up_valid;
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rdy && up_valid) begin
      out_x <= sat32(tx);
      out_y <= sat32(ty);
      out_z <= sat32(tz);
      out_u <= u;
      out_v <= v;
      last_out <= last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/instance_vertex_transform.sv @@
// top level: configuration registers, trig unit and the transform pipeline
//
// Input beats carry one vertex (pos_x/y/z, tex_u, tex_v, last_in) on an
// in_valid / in_ready channel; results leave on out_valid / out_ready with
// the transformed position, u unchanged, v flipped and the last flag.
// Between input beat and output beat lie two scale stages, two stages for
// each of the three rotations and one output register. Throughput is one
// vertex per cycle while in_ready is high; each stage has its own valid bit,
// so a stall by the receiver backs up stage by stage and bubbles close up.
// The configuration port writes one register per cycle on cfg_we.
// Sine and cosine come from one shared cordic that runs 30 iterations per
// angle for each of the three angles; it starts after reset and after any
// angle write, and in_ready stays low until it finishes; an angle write
// during a pass adds one more full pass after it.
// Reset sets the scale to one, angles and offsets to zero, and empties
// the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module instance_vertex_transform import ivt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] tex_u,
  input  wire logic signed [31:0] tex_v,
  input  wire logic               last_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_u,
  output logic signed [31:0]      out_v,
  output logic                    last_out
);

  logic [23:0] scale_factor;
  logic [15:0] angle_x;
  logic [15:0] angle_y;
  logic [15:0] angle_z;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic angle_write;

  logic trig_ok;
  trig_t trig_x;
  trig_t trig_y;
  trig_t trig_z;

  logic scale_ready;
  logic s_valid;
  logic s_ready;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [CW-1:0] sz;
  logic signed [31:0] su;
  logic signed [31:0] sv;
  logic slast;
  side_t side_s;

  logic rx_valid;
  logic rx_ready;
  logic signed [CW-1:0] y1;
  logic signed [CW-1:0] z1;
  side_t side_x;
  side_t side_yin;

  logic ry_valid;
  logic ry_ready;
  logic signed [CW-1:0] z2;
  logic signed [CW-1:0] x2;
  side_t side_y;
  side_t side_zin;

  logic rz_valid;
  logic rz_ready;
  logic signed [CW-1:0] x3;
  logic signed [CW-1:0] y3;
  side_t side_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= 24'd65536;
      angle_x  <= '0;
      angle_y  <= '0;
      angle_z  <= '0;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:    scale_factor <= cfg_data[23:0];
        REG_ANGLE_X:  angle_x <= cfg_data[15:0];
        REG_ANGLE_Y:  angle_y <= cfg_data[15:0];
        REG_ANGLE_Z:  angle_z <= cfg_data[15:0];
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign angle_write = cfg_we && (cfg_index == REG_ANGLE_X ||
                       cfg_index == REG_ANGLE_Y || cfg_index == REG_ANGLE_Z);

  ivt_trig u_trig (
    .clk, .rst, .angle_x, .angle_y, .angle_z, .angle_write,
    .trig_ok, .trig_x, .trig_y, .trig_z
  );

  // input beats wait for the trig unit
  assign in_ready = trig_ok && scale_ready;

  ivt_scale u_scale (
    .clk, .rst,
    .up_valid(in_valid && trig_ok), .up_ready(scale_ready),
    .pos_x, .pos_y, .pos_z, .tex_u, .tex_v, .last_in, .scale_factor,
    .dn_valid(s_valid), .dn_ready(s_ready),
    .sx, .sy, .sz, .su, .sv, .slast
  );

  // rotation about x: a = y, b = z
  assign side_s = '{w: sx, u: su, v: sv, last: slast};

  ivt_rotate u_rot_x (
    .clk, .rst, .up_valid(s_valid), .up_ready(s_ready),
    .a(sy), .b(sz), .side_in(side_s), .cs(trig_x),
    .dn_valid(rx_valid), .dn_ready(rx_ready),
    .r0(y1), .r1(z1), .side_out(side_x)
  );

  // rotation about y: a = z, b = x
  always_comb begin
    side_yin = side_x;
    side_yin.w = y1;
  end

  ivt_rotate u_rot_y (
    .clk, .rst, .up_valid(rx_valid), .up_ready(rx_ready),
    .a(z1), .b(side_x.w), .side_in(side_yin), .cs(trig_y),
    .dn_valid(ry_valid), .dn_ready(ry_ready),
    .r0(z2), .r1(x2), .side_out(side_y)
  );

  // rotation about z: a = x, b = y
  always_comb begin
    side_zin = side_y;
    side_zin.w = z2;
  end

  ivt_rotate u_rot_z (
    .clk, .rst, .up_valid(ry_valid), .up_ready(ry_ready),
    .a(x2), .b(side_y.w), .side_in(side_zin), .cs(trig_z),
    .dn_valid(rz_valid), .dn_ready(rz_ready),
    .r0(x3), .r1(y3), .side_out(side_z)
  );

  ivt_output u_out (
    .clk, .rst, .up_valid(rz_valid), .up_ready(rz_ready),
    .x(x3), .y(y3), .z(side_z.w), .u(side_z.u), .v(side_z.v), .last(side_z.last),
    .offset_x, .offset_y, .offset_z,
    .out_valid, .out_ready, .out_x, .out_y, .out_z, .out_u, .out_v, .last_out
  );

  // no beat is taken while sine and cosine are being refreshed
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    !trig_ok |-> !in_ready)
    else $error("input accepted while trig unit busy");

  // an angle write always triggers a refresh
  a_angle_refresh: assert property (@(posedge clk) disable iff (rst)
    angle_write |=> !trig_ok)
    else $error("angle write did not restart trig unit");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
